// ===== rtl/assert_macros.svh =====
// Assertion macros for the page access profiler RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define AST_IMP(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/pap_pkg.sv =====
// Types, constants and helper functions of the page access profiler.
// No dependencies; imported by every module of the block.
package pap_pkg;

  localparam int ADDR_W = 64;
  localparam int PAGE_W = 52;
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 32;
  localparam int KIND_W = 2;
  localparam int KINDS  = 4;

  localparam logic [KIND_W-1:0] KIND_INSTR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [KIND_W-1:0] access_kind;
    logic [ADDR_W-1:0] access_address;
  } pap_in_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic [SLOT_W-1:0] slot;
    logic              page_is_new;
    logic [CNT_W-1:0]  instr_count;
    logic [CNT_W-1:0]  data_count;
    logic [CNT_W-1:0]  kind_total;
    logic              table_full;
  } pap_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CNT_RD,
    ST_CNT_UPD,
    ST_INSERT,
    ST_FULL,
    ST_DONE
  } pap_state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic hit_take;
    logic cnt_rd;
    logic cnt_wr;
    logic ins_new;
    logic res_full;
    logic out_load;
  } pap_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic full;
  } pap_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/pap_ctrl.sv =====
// Controller of the page access profiler: sequences search, update and output.
// Depends on pap_pkg; drives the datapath through pap_cmd_t.
module pap_ctrl
  import pap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  pap_status_t status,
  output pap_cmd_t    cmd
);

  pap_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        priority if (status.hit) begin
          cmd.hit_take = 1'b1;
          state_nxt    = ST_CNT_RD;
        end else if (status.exhausted) begin
          state_nxt = status.full ? ST_FULL : ST_INSERT;
        end
      end
      ST_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = ST_CNT_UPD;
      end
      ST_CNT_UPD: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_INSERT: begin
        cmd.ins_new = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_FULL: begin
        cmd.res_full = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready)        out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/pap_dpath.sv =====
// Datapath of the page access profiler: page table, counter memories, totals.
// Depends on pap_pkg; steered by pap_ctrl through pap_cmd_t and pap_status_t.
module pap_dpath
  import pap_pkg::*;
#(
  parameter int TABLE_ENTRIES    = 64,
  parameter int PAGE_OFFSET_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pap_in_t     in_data,
  input  pap_cmd_t    cmd,
  output pap_status_t status,
  output pap_out_t    out_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int UW = $clog2(TABLE_ENTRIES + 1);

  logic [PAGE_W-1:0] tag_mem  [TABLE_ENTRIES];
  logic [CNT_W-1:0]  icnt_mem [TABLE_ENTRIES];
  logic [CNT_W-1:0]  dcnt_mem [TABLE_ENTRIES];

  logic [CNT_W-1:0]  kt_r [KINDS];
  logic [CNT_W-1:0]  kt_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [CNT_W-1:0]  ktot_r;
  logic [UW-1:0]     used_r;
  logic [UW-1:0]     rd_idx_r;
  logic [IW-1:0]     cmp_idx_r;
  logic              cmp_v_r;
  logic [PAGE_W-1:0] tag_q_r;
  logic [IW-1:0]     slot_r;
  logic [CNT_W-1:0]  ic_q_r, dc_q_r;
  logic [CNT_W-1:0]  ic_nxt, dc_nxt;
  logic              is_instr;
  logic              issue;
  logic              hit;
  logic              cnt_we;
  logic [IW-1:0]     cnt_wa;
  pap_out_t          res_r, out_r;

  assign page_nxt = PAGE_W'(in_data.access_address >> PAGE_OFFSET_BITS);
  assign kt_nxt   = sat_inc(kt_r[in_data.access_kind]);
  assign is_instr = (kind_r == KIND_INSTR);
  assign hit      = cmp_v_r && (tag_q_r == page_r);
  assign issue    = cmd.search && !hit && (rd_idx_r != used_r);

  assign status.hit       = hit;
  assign status.exhausted = !cmp_v_r && (rd_idx_r == used_r);
  assign status.full      = (used_r == UW'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KINDS; k++) kt_r[k] <= '0;
      used_r   <= '0;
      rd_idx_r <= '0;
      cmp_v_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        kt_r[in_data.access_kind] <= kt_nxt;
        rd_idx_r <= '0;
        cmp_v_r  <= 1'b0;
      end else begin
        cmp_v_r <= issue;
        if (issue) rd_idx_r <= rd_idx_r + UW'(1);
      end
      if (cmd.ins_new) used_r <= used_r + UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_data.access_kind;
      page_r <= page_nxt;
      ktot_r <= kt_nxt;
    end
    if (issue) begin
      tag_q_r   <= tag_mem[rd_idx_r[IW-1:0]];
      cmp_idx_r <= rd_idx_r[IW-1:0];
    end
    if (cmd.hit_take) slot_r <= cmp_idx_r;
    if (cmd.ins_new)  slot_r <= used_r[IW-1:0];
    if (cmd.cnt_rd) begin
      ic_q_r <= icnt_mem[slot_r];
      dc_q_r <= dcnt_mem[slot_r];
    end
  end

  always_comb begin
    if (cmd.ins_new) begin
      ic_nxt = is_instr ? CNT_W'(1) : '0;
      dc_nxt = is_instr ? '0 : CNT_W'(1);
      cnt_wa = used_r[IW-1:0];
    end else begin
      ic_nxt = is_instr ? sat_inc(ic_q_r) : ic_q_r;
      dc_nxt = is_instr ? dc_q_r : sat_inc(dc_q_r);
      cnt_wa = slot_r;
    end
  end

  assign cnt_we = cmd.ins_new || cmd.cnt_wr;

  always_ff @(posedge clk) begin
    if (cmd.ins_new) tag_mem[used_r[IW-1:0]] <= page_r;
    if (cnt_we) begin
      icnt_mem[cnt_wa] <= ic_nxt;
      dcnt_mem[cnt_wa] <= dc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we || cmd.res_full) begin
      res_r.page_number <= page_r;
      res_r.kind_total  <= ktot_r;
      res_r.page_is_new <= cmd.ins_new;
      res_r.table_full  <= cmd.res_full;
      res_r.slot        <= cmd.res_full ? '0 : SLOT_W'(cnt_wa);
      res_r.instr_count <= cmd.res_full ? '0 : ic_nxt;
      res_r.data_count  <= cmd.res_full ? '0 : dc_nxt;
    end
    if (cmd.out_load) out_r <= res_r;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/page_access_profiler.sv =====
// Page access profiler: a record is accepted only while the block is idle and
// its result leaves through an output register, so the next record may enter
// while that result waits. The block is ready for the next record in the same
// cycle that the result of the last one turns valid. The search time is set
// by the tag search, which reads one table entry per cycle from the tag
// memory, from position 0 up to a hit or up to the entries in use. Reset needs
// no clearing pass.
module page_access_profiler
  import pap_pkg::*;
#(
  parameter int TABLE_ENTRIES    = 64,
  parameter int PAGE_OFFSET_BITS = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pap_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pap_out_t out_data
);

`include "assert_macros.svh"

  pap_cmd_t    cmd;
  pap_status_t status;

  pap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pap_dpath #(
    .TABLE_ENTRIES    (TABLE_ENTRIES),
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  `AST_IMP(a_cmd_excl, 1'b1,
    $onehot0({cmd.load, cmd.cnt_wr, cmd.ins_new, cmd.res_full, cmd.out_load}))
  `AST_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `AST_IMP(a_full_clean, out_valid && out_data.table_full,
    !out_data.page_is_new && (out_data.instr_count == '0) && (out_data.data_count == '0))
  `AST_IMP(a_new_single, out_valid && out_data.page_is_new,
    (out_data.instr_count == 32'd1) != (out_data.data_count == 32'd1))

endmodule
